>>> design/urtc_pkg.sv
// shared constants and types for the uart receiver with text cursor
// no dependencies; imported by urtc_rx, urtc_cursor and uart_rx_text_cursor
`timescale 1ns / 1ps

package urtc_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 160;
	localparam int DATA_BITS     = 8;

	localparam int CELL_W            = 6;
	localparam int CELL_H            = 9;
	localparam int HOME_COL          = 1;
	localparam int HOME_ROW          = 9;
	localparam int FIRST_SAMPLE_TICK = 3;

	localparam logic [7:0]  CH_BACKSPACE   = 8'h7F;
	localparam logic [15:0] HALF_BIT_RESET = 16'd1302;

	localparam logic [4:0] FIRST_TICK = 5'(FIRST_SAMPLE_TICK);
	localparam logic [4:0] LAST_TICK  = 5'(2 * DATA_BITS + 1);
	localparam logic [4:0] DONE_TICK  = 5'(2 * DATA_BITS + 2);

	typedef struct packed {
		logic       done;
		logic [7:0] ch;
	} char_evt_t;

	typedef struct packed {
		logic [7:0] rx_char;
		logic       is_backspace;
		logic [6:0] draw_x;
		logic [7:0] draw_y;
		logic [6:0] cursor_x;
		logic [7:0] cursor_y;
		logic       clear_screen;
	} result_t;

endpackage

>>> design/uart_rx_text_cursor.sv
// top level: input register, receiver, cursor update and result register
// depends on urtc_pkg, urtc_rx, urtc_cursor
`timescale 1ns / 1ps

// One word on the input channel is one clock sample of the receive line, and the
// block takes one word per clock unless stalled. A word enters an input register;
// from there the receiver and cursor logic act on it, and when it completes a
// character the result goes into an output register. A finished character holds
// the input register only while the output register still has an untaken word;
// otherwise samples stream through without a gap. The half-bit period is
// half_bit_cycles+1 samples, so a character yields one result roughly every
// 18*(half_bit_cycles+1) samples. The half-bit register resets to 1302 and is
// written through the cfg channel, which is always ready.
module uart_rx_text_cursor import urtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        rx_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  rx_char,
	output logic        is_backspace,
	output logic [6:0]  draw_x,
	output logic [7:0]  draw_y,
	output logic [6:0]  cursor_x,
	output logic [7:0]  cursor_y,
	output logic        clear_screen
);

	logic [15:0] half_bit_q;
	logic        valid_s1;
	logic        level_s1;
	logic        out_valid_q;
	result_t     out_q;

	char_evt_t evt;
	result_t   res;
	logic      out_free;
	logic      advance;
	logic      fire_s1;
	logic      commit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= HALF_BIT_RESET;
		end else if (cfg_valid) begin
			half_bit_q <= cfg_data;
		end
	end

	// a finished character waits only when the result register is still full
	assign out_free = !out_valid_q || out_ready;
	assign advance  = !evt.done || out_free;
	assign fire_s1  = valid_s1 && advance;
	assign commit   = fire_s1 && evt.done;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= rx_level;
		end
	end

	urtc_rx u_rx (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (fire_s1),
		.level           (level_s1),
		.half_bit_cycles (half_bit_q),
		.evt             (evt)
	);

	urtc_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.evt    (evt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign rx_char      = out_q.rx_char;
	assign is_backspace = out_q.is_backspace;
	assign draw_x       = out_q.draw_x;
	assign draw_y       = out_q.draw_y;
	assign cursor_x     = out_q.cursor_x;
	assign cursor_y     = out_q.cursor_y;
	assign clear_screen = out_q.clear_screen;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !out_valid_q || out_ready)
		else $error("finished character overwrote an untaken result");

endmodule

>>> design/urtc_rx.sv
// serial receiver: edge detect, half-bit timer, data bit sampling
// depends on urtc_pkg
`timescale 1ns / 1ps

module urtc_rx import urtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        level,
	input  logic [15:0] half_bit_cycles,
	output char_evt_t   evt
);

	logic        last_level_q;
	logic        receiving_q;
	logic [15:0] clock_count_q;
	logic [4:0]  half_tick_q;
	logic [7:0]  shift_q;

	logic       tick;
	logic [4:0] tick_next;
	logic [4:0] tick_off;
	logic [2:0] pos;
	logic       sample;
	logic       done;

	always_comb begin
		tick      = receiving_q && (clock_count_q == half_bit_cycles);
		tick_next = half_tick_q + 5'd1;
		tick_off  = tick_next - FIRST_TICK;
		pos       = tick_off[3:1];
		sample    = tick && (tick_next >= FIRST_TICK) && (tick_next <= LAST_TICK)
			&& tick_next[0];
		done      = tick && (tick_next == DONE_TICK);
		evt.done  = done;
		evt.ch    = shift_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b1;
			receiving_q   <= 1'b0;
			clock_count_q <= '0;
			half_tick_q   <= '0;
			shift_q       <= '0;
		end else if (step) begin
			last_level_q <= level;
			if (receiving_q) begin
				if (tick) begin
					clock_count_q <= '0;
					if (done) begin
						receiving_q <= 1'b0;
						half_tick_q <= '0;
						shift_q     <= '0;
					end else begin
						half_tick_q <= tick_next;
						if (sample) begin
							shift_q[pos] <= shift_q[pos] | level;
						end
					end
				end else begin
					clock_count_q <= clock_count_q + 16'd1;
				end
			end else if (last_level_q && !level) begin
				// start bit edge
				receiving_q   <= 1'b1;
				clock_count_q <= '0;
				half_tick_q   <= '0;
				shift_q       <= '0;
			end
		end
	end

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		half_tick_q < DONE_TICK)
		else $error("half tick count ran past the end of a character");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> !receiving_q && half_tick_q == 5'd0)
		else $error("receiver did not return to idle after a character");

endmodule

>>> design/urtc_cursor.sv
// text cursor: places a finished character on the grid and moves the cursor
// depends on urtc_pkg
`timescale 1ns / 1ps

module urtc_cursor import urtc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      commit,
	input  char_evt_t evt,
	output result_t   res
);

	logic [7:0] cur_col_q;
	logic [7:0] cur_row_q;

	logic [8:0] col_adv;
	logic [8:0] row_adv;
	logic [8:0] col_t;
	logic [8:0] row_t;
	logic [7:0] nx_col;
	logic [7:0] nx_row;
	logic       bs;
	logic       clr;

	always_comb begin
		col_adv = {1'b0, cur_col_q} + 9'(CELL_W);
		row_adv = {1'b0, cur_row_q} + 9'(CELL_H);
		bs      = (evt.ch == CH_BACKSPACE);
		clr     = 1'b0;
		col_t   = {1'b0, cur_col_q};
		row_t   = {1'b0, cur_row_q};
		nx_col  = cur_col_q;
		nx_row  = cur_row_q;
		if (!bs) begin
			col_t = col_adv;
			if (col_adv > 9'(SCREEN_WIDTH - CELL_W)) begin
				col_t = 9'(HOME_COL);
				row_t = row_adv;
			end
			// wrapped past the bottom: home and clear
			if (row_t > 9'(SCREEN_HEIGHT - CELL_H)) begin
				col_t = 9'(HOME_COL);
				row_t = 9'(HOME_ROW);
				clr   = 1'b1;
			end
			nx_col = col_t[7:0];
			nx_row = row_t[7:0];
		end else if (cur_col_q == 8'(HOME_COL) && cur_row_q == 8'(HOME_ROW)) begin
			nx_col = cur_col_q;
			nx_row = cur_row_q;
		end else if (cur_col_q < 8'(CELL_W)) begin
			if (cur_row_q >= 8'(CELL_H + HOME_ROW)) begin
				// unwrap to the end of the previous row
				nx_col = 8'(SCREEN_WIDTH - CELL_W - 3);
				nx_row = cur_row_q - 8'(CELL_H);
			end else begin
				nx_col = 8'(HOME_COL);
				nx_row = 8'(HOME_ROW);
			end
		end else begin
			nx_col = cur_col_q - 8'(CELL_W);
		end

		res.rx_char      = evt.ch;
		res.is_backspace = bs;
		res.draw_x       = cur_col_q[6:0];
		res.draw_y       = cur_row_q;
		res.cursor_x     = nx_col[6:0];
		res.cursor_y     = nx_row;
		res.clear_screen = clr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 8'(HOME_COL);
			cur_row_q <= 8'(HOME_ROW);
		end else if (commit) begin
			cur_col_q <= nx_col;
			cur_row_q <= nx_row;
		end
	end

	a_cursor_on_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q >= 8'(HOME_COL) && cur_col_q <= 8'(SCREEN_WIDTH - CELL_W)
		&& cur_row_q >= 8'(HOME_ROW) && cur_row_q <= 8'(SCREEN_HEIGHT - CELL_H))
		else $error("cursor left the character grid");

endmodule

>>> verif/testbench.sv
// testbench for uart_rx_text_cursor: serial frames in, cursor results checked
// against a sample-by-sample predictor of the receiver and the text cursor
// depends on urtc_pkg and the uart_rx_text_cursor design files
`timescale 1ns / 1ps

module testbench import urtc_pkg::*; ();

	typedef enum {FRAME_CLEAN, FRAME_SHORT_STOP, FRAME_JITTER, FRAME_BAD_STOP} frame_kind_t;
	typedef enum {RDY_ALWAYS, RDY_THREE_OF_FOUR, RDY_HALF, RDY_SPARSE} ready_mode_t;

	localparam int N_ITEMS = 1550;

	class cursor_scoreboard;
		logic [15:0] half_bit;
		bit          last_lvl;
		bit          busy;
		logic [15:0] clk_cnt;
		logic [4:0]  tick;
		logic [7:0]  shreg;
		logic [7:0]  col;
		logic [7:0]  row;
		result_t     due_results[$];
		int          mismatches;

		function new();
			half_bit = HALF_BIT_RESET;
			last_lvl = 1'b1;
			busy = 1'b0;
			clk_cnt = '0;
			tick = '0;
			shreg = '0;
			col = 8'(HOME_COL);
			row = 8'(HOME_ROW);
			mismatches = 0;
		endfunction

		function void place_char();
			int c;
			int r;
			result_t e;
			c = col;
			r = row;
			e.rx_char = shreg;
			e.is_backspace = (shreg == CH_BACKSPACE);
			e.draw_x = col[6:0];
			e.draw_y = row;
			e.clear_screen = 1'b0;
			if (!e.is_backspace) begin
				c += CELL_W;
				if (c > SCREEN_WIDTH - CELL_W) begin
					c = HOME_COL;
					r += CELL_H;
				end
				if (r > SCREEN_HEIGHT - CELL_H) begin
					c = HOME_COL;
					r = HOME_ROW;
					e.clear_screen = 1'b1;
				end
			end else if (c == HOME_COL && r == HOME_ROW) begin
				// backspace at home does nothing
			end else if (c < CELL_W) begin
				// row start: unwrap to the end of the row above, top row goes home
				if (r >= CELL_H + HOME_ROW) begin
					c = SCREEN_WIDTH - CELL_W - 3;
					r -= CELL_H;
				end else begin
					c = HOME_COL;
					r = HOME_ROW;
				end
			end else begin
				c -= CELL_W;
			end
			e.cursor_x = 7'(c);
			e.cursor_y = 8'(r);
			col = 8'(c);
			row = 8'(r);
			shreg = '0;
			due_results.push_back(e);
		endfunction

		// one accepted word is one clock sample of the line
		function void take_sample(bit lvl);
			if (busy) begin
				if (clk_cnt == half_bit) begin
					clk_cnt = '0;
					tick = tick + 5'd1;
					if (tick >= FIRST_TICK && tick <= LAST_TICK && tick[0])
						shreg = shreg | (8'(lvl) << ((tick - FIRST_TICK) >> 1));
					else if (tick == DONE_TICK) begin
						busy = 1'b0;
						tick = '0;
						place_char();
					end
				end else begin
					clk_cnt = clk_cnt + 16'd1;
				end
			end else if (last_lvl && !lvl) begin
				busy = 1'b1;
				clk_cnt = '0;
				tick = '0;
				shreg = '0;
			end
			last_lvl = lvl;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function string show(result_t r);
			return $sformatf("char %02h bs %0d draw (%0d,%0d) cursor (%0d,%0d) clear %0d",
				r.rx_char, r.is_backspace, r.draw_x, r.draw_y, r.cursor_x, r.cursor_y,
				r.clear_screen);
		endfunction

		function void note_fail(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (due_results.size() == 0) begin
				note_fail({"result with none expected: ", show(got)});
			end else begin
				e = due_results.pop_front();
				if (got !== e)
					note_fail({"expected ", show(e), " got ", show(got)});
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        rx_level;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  rx_char;
	logic        is_backspace;
	logic [6:0]  draw_x;
	logic [7:0]  draw_y;
	logic [6:0]  cursor_x;
	logic [7:0]  cursor_y;
	logic        clear_screen;

	cursor_scoreboard sb = new();

	int burst_left;
	int gap_left;
	int half_len;
	int samples_sent;
	int taken;

	logic [7:0]  opening_chars [12] = '{8'h7F, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
		8'h80, 8'h7F, 8'h7F, 8'h7F, 8'h20, 8'h7F};
	logic [15:0] seg_rates [10] = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2,
		16'd3, 16'd5, 16'd1};

	uart_rx_text_cursor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_level     (rx_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rx_char      (rx_char),
		.is_backspace (is_backspace),
		.draw_x       (draw_x),
		.draw_y       (draw_y),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.clear_screen (clear_screen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sender bursts with random gaps, now and then a long burst with no gap
	task automatic send_sample(bit lvl);
		while (gap_left > 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		in_valid <= 1'b1;
		rx_level <= lvl;
		do @(posedge clk); while (!in_ready);
		sb.take_sample(lvl);
		samples_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
	endtask

	task automatic send_level(bit lvl, int n);
		repeat (n) send_sample(lvl);
	endtask

	task automatic send_noise(int n);
		repeat (n) send_sample(1'($urandom_range(0, 1)));
	endtask

	task automatic send_frame(logic [7:0] b, frame_kind_t kind);
		int len;
		send_level(1'b0, 2 * half_len);
		for (int i = 0; i < DATA_BITS; i++) begin
			len = 2 * half_len;
			if (kind == FRAME_JITTER)
				len += int'($urandom_range(0, 2)) - 1;
			send_level(b[i], len);
		end
		case (kind)
			FRAME_SHORT_STOP: send_level(1'b1, $urandom_range(1, 2 * half_len - 1));
			FRAME_BAD_STOP: begin
				// line still low when the character finishes
				send_level(1'b0, 2 * half_len);
				send_level(1'b1, 2 * half_len);
			end
			default: send_level(1'b1, 2 * half_len);
		endcase
	endtask

	task automatic send_char(logic [7:0] b);
		int r;
		frame_kind_t kind;
		r = $urandom_range(0, 99);
		if (r < 3)
			send_noise($urandom_range(1, 12));
		else if (r >= 50)
			send_level(1'b1, $urandom_range(1, 3 * half_len));
		r = $urandom_range(0, 99);
		kind = (r < 80) ? FRAME_CLEAN : (r < 90) ? FRAME_SHORT_STOP :
			(r < 96) ? FRAME_JITTER : FRAME_BAD_STOP;
		send_frame(b, kind);
	endtask

	// finish any character in progress and let every result drain first
	task automatic settle_then_write(logic [15:0] v);
		while (sb.busy)
			send_sample(1'b1);
		send_level(1'b1, 2);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.half_bit = v;
		half_len = int'(v) + 1;
	endtask

	initial begin
		int          seg_len;
		int          sent;
		int          run;
		bit          bs_run;
		int          waited;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_level <= 1'b1;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		burst_left = 20;
		gap_left = 0;
		half_len = int'(HALF_BIT_RESET) + 1;
		samples_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// a few idle samples at the reset rate
		send_level(1'b1, 4);

		// largest match value, line kept idle
		settle_then_write(16'hFFFF);
		send_level(1'b1, 20);

		settle_then_write(16'd1);
		send_level(1'b1, 3);
		foreach (opening_chars[i])
			send_frame(opening_chars[i], FRAME_CLEAN);
		// falling edge right on the finishing sample, then a stop held low
		send_frame(8'hC3, FRAME_BAD_STOP);
		// short stop with the next start straight after
		send_frame(8'h3C, FRAME_SHORT_STOP);
		send_frame(8'h66, FRAME_CLEAN);
		send_noise(20);

		settle_then_write(16'd12);
		send_frame(8'h7E, FRAME_CLEAN);

		while (samples_sent < N_ITEMS) begin
			settle_then_write(seg_rates[$urandom_range(0, 9)]);
			seg_len = $urandom_range(2, 8);
			sent = 0;
			while (sent < seg_len && samples_sent < N_ITEMS) begin
				if ($urandom_range(0, 24) == 0)
					send_noise($urandom_range(5, 40));
				bs_run = ($urandom_range(0, 4) == 0);
				run = $urandom_range(1, 4);
				for (int k = 0; k < run && samples_sent < N_ITEMS; k++)
					send_char(bs_run ? CH_BACKSPACE : 8'($urandom_range(0, 255)));
				sent += run;
			end
		end

		while (sb.busy)
			send_sample(1'b1);
		send_level(1'b1, 2);
		in_valid <= 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d expected results never arrived", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("uart_rx_text_cursor test passed");
		else
			$display("uart_rx_text_cursor test failed");
		$finish;
	end

	// receiver: stall mode picked at random from four modes, one long hold-off
	initial begin
		int          hold_left;
		int          cyc;
		bit          long_hold_done;
		ready_mode_t mode;
		result_t     got;
		out_ready <= 1'b0;
		hold_left = 0;
		cyc = 0;
		long_hold_done = 1'b0;
		mode = RDY_ALWAYS;
		taken = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {rx_char, is_backspace, draw_x, draw_y, cursor_x, cursor_y, clear_screen};
				sb.check_result(got);
				taken++;
			end
			cyc++;
			if (cyc % 128 == 0)
				mode = ready_mode_t'($urandom_range(0, 3));
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && taken == 6) begin
				// sender keeps going so the block backs up and stalls its input
				long_hold_done = 1'b1;
				hold_left = 600;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RDY_ALWAYS:        out_ready <= 1'b1;
					RDY_THREE_OF_FOUR: out_ready <= (cyc % 4 != 0);
					RDY_HALF:          out_ready <= 1'($urandom_range(0, 1));
					default:           out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin
		#20_000_000;
		$display("uart_rx_text_cursor test failed");
		$finish;
	end

endmodule
